// ===== rtl/b2da_pkg.sv =====
package b2da_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 6;
   localparam int COUNT_WIDTH = 3;
   localparam int LOW_DIGITS  = 4;
   localparam int MAX_DIGITS  = 5;

   // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 16-bit v
   localparam logic [VALUE_WIDTH-1:0] RECIP_TEN   = 16'd52429;
   localparam int                     RECIP_SHIFT = 19;
   localparam logic [DIGIT_WIDTH-1:0] DEC_BASE    = 4'd10;
   localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO  = 6'd48;

   typedef logic [LOW_DIGITS-1:0][DIGIT_WIDTH-1:0] low_digits_type;
   typedef logic [MAX_DIGITS-1:0][DIGIT_WIDTH-1:0] digits_type;

   typedef struct packed {
      logic                   valid;
      logic [VALUE_WIDTH-1:0] value;
      low_digits_type         digits;
   } stage_type;

endpackage

// ===== rtl/binary_to_decimal_ascii.sv =====
// Converts an unsigned 16-bit number on the req_ channel into its decimal
// text, one ASCII digit per rsp_ transaction, most significant digit first,
// leading zeros dropped (zero gives a single '0'); rsp_last marks the final
// digit. Four divide-by-ten stages, one multiply by a reciprocal each, take a
// new number every cycle while req_stall is low. An idle output serializer
// loads the digits once the number reaches the last stage, and moves them one
// at a time into its output register whenever that register is free; it takes
// the next number only after the last digit and moves no digit while it
// loads. Up to four more numbers wait in the stages behind it. The stages do
// not close gaps, so req_stall rises whenever the last stage holds a number
// that the serializer cannot take yet.
module binary_to_decimal_ascii (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [b2da_pkg::CHAR_WIDTH-1:0]     rsp_digit_char,
   output logic                                rsp_last
);

   b2da_pkg::stage_type link [b2da_pkg::LOW_DIGITS+1];
   logic                advance;
   logic                load;

   assign advance = !link[b2da_pkg::LOW_DIGITS].valid || load;
   assign req_stall = !advance;

   assign link[0].valid  = req_valid;
   assign link[0].value  = req_value;
   assign link[0].digits = '0;

   for (genvar g = 0; g < b2da_pkg::LOW_DIGITS; g++) begin : g_stage
      b2da_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (link[g]),
         .stage_out (link[g+1])
      );
   end

   b2da_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .stage_in       (link[b2da_pkg::LOW_DIGITS]),
      .load           (load),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== rtl/b2da_div_stage.sv =====
module b2da_div_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  b2da_pkg::stage_type stage_in,
   output b2da_pkg::stage_type stage_out
);

   logic [2*b2da_pkg::VALUE_WIDTH-1:0] product;
   logic [b2da_pkg::VALUE_WIDTH-1:0]   quotient;
   logic [b2da_pkg::VALUE_WIDTH-1:0]   times_ten;
   logic [b2da_pkg::VALUE_WIDTH-1:0]   remainder;

   logic                               valid_ff;
   logic [b2da_pkg::VALUE_WIDTH-1:0]   value_ff;
   b2da_pkg::low_digits_type           digits_ff;

   always_comb begin
      product   = stage_in.value * b2da_pkg::RECIP_TEN;
      quotient  = b2da_pkg::VALUE_WIDTH'(product >> b2da_pkg::RECIP_SHIFT);
      times_ten = quotient * b2da_pkg::VALUE_WIDTH'(b2da_pkg::DEC_BASE);
      remainder = stage_in.value - times_ten;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   // shift the new digit in from the top
   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff  <= quotient;
         digits_ff <= {remainder[b2da_pkg::DIGIT_WIDTH-1:0],
                       stage_in.digits[b2da_pkg::LOW_DIGITS-1:1]};
      end
   end

   assign stage_out.valid  = valid_ff;
   assign stage_out.value  = value_ff;
   assign stage_out.digits = digits_ff;

endmodule

// ===== rtl/b2da_serializer.sv =====
module b2da_serializer (
   input  logic                                clock,
   input  logic                                reset,
   input  b2da_pkg::stage_type                 stage_in,
   output logic                                load,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [b2da_pkg::CHAR_WIDTH-1:0]     rsp_digit_char,
   output logic                                rsp_last
);

   b2da_pkg::digits_type                 digit_store_ff;
   b2da_pkg::digits_type                 new_digits;
   logic [b2da_pkg::COUNT_WIDTH-1:0]     digits_left_ff;
   logic [b2da_pkg::COUNT_WIDTH-1:0]     digits_left_in;
   logic [b2da_pkg::COUNT_WIDTH-1:0]     count;
   logic [b2da_pkg::COUNT_WIDTH-1:0]     idx;
   logic                                 out_free;
   logic                                 valid_ff;
   logic                                 valid_in;
   logic [b2da_pkg::CHAR_WIDTH-1:0]      char_ff;
   logic [b2da_pkg::CHAR_WIDTH-1:0]      char_in;
   logic                                 last_ff;
   logic                                 last_in;

   always_comb begin
      new_digits = {stage_in.value[b2da_pkg::DIGIT_WIDTH-1:0], stage_in.digits};
      if (new_digits[4] != '0) begin
         count = 3'd5;
      end else if (new_digits[3] != '0) begin
         count = 3'd4;
      end else if (new_digits[2] != '0) begin
         count = 3'd3;
      end else if (new_digits[1] != '0) begin
         count = 3'd2;
      end else begin
         count = 3'd1;
      end
   end

   always_comb begin
      load           = stage_in.valid && (digits_left_ff == '0);
      out_free       = !valid_ff || !rsp_stall;
      idx            = digits_left_ff - 3'd1;
      digits_left_in = digits_left_ff;
      valid_in       = valid_ff;
      char_in        = char_ff;
      last_in        = last_ff;
      if (load) begin
         digits_left_in = count;
      end
      if (out_free) begin
         if (digits_left_ff != '0) begin
            valid_in       = 1'b1;
            char_in        = b2da_pkg::ASCII_ZERO
                             + b2da_pkg::CHAR_WIDTH'(digit_store_ff[idx]);
            last_in        = (digits_left_ff == 3'd1);
            digits_left_in = idx;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_left_ff <= '0;
         valid_ff       <= 1'b0;
      end else begin
         digits_left_ff <= digits_left_in;
         valid_ff       <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      if (load) begin
         digit_store_ff <= new_digits;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== rtl/b2da_checker.sv =====
module b2da_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [b2da_pkg::CHAR_WIDTH-1:0] rsp_digit_char,
   input logic                            rsp_last
);

   logic       run_start_ff;
   logic [2:0] run_len_ff;
   logic       rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_start_ff <= 1'b1;
         run_len_ff   <= '0;
      end else if (rsp_take) begin
         run_start_ff <= rsp_last;
         run_len_ff   <= rsp_last ? 3'd0 : run_len_ff + 3'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last))
      else $error("stalled transaction changed");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_char >= 6'd48 && rsp_digit_char <= 6'd57)
      else $error("character is not a decimal digit");

   a_no_leading_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_start_ff && rsp_digit_char == 6'd48 |-> rsp_last)
      else $error("leading zero emitted");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      rsp_take && run_len_ff == 3'd4 |-> rsp_last)
      else $error("run longer than five digits");

endmodule

bind binary_to_decimal_ascii b2da_checker u_checker (.*);
